FILE: hdl/jet_pkg.sv
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types, constants and helpers for the Julia escape-time pixel core.
// ----------------------------------------------------------------------------
package jet_pkg;

    // Iteration limit and grid size
    localparam int MAX_ITER  = 12;
    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 48;
    localparam int COL_HALF  = GRID_COLS / 2;
    localparam int ROW_HALF  = GRID_ROWS / 2;
    localparam int START_MUL = 3;

    // Field widths
    localparam int COL_W   = 6;
    localparam int ROW_W   = 6;
    localparam int C_W     = 8;
    localparam int OFF_W   = 3;
    localparam int ITER_W  = 4;
    localparam int SCR_W   = 8;
    localparam int CNT_W   = $clog2(MAX_ITER + 1);
    localparam int IN_W    = 16;
    localparam int OUT_W   = 32;
    localparam int CFG_I_W = 2;

    // Working width of z: escape test keeps |z| within +/-256 after a step
    localparam int Z_W  = 10;
    localparam int SQ_W = 2 * Z_W + 1;

    // Escape limits and fixed-point scale
    localparam int ESC_MAG = 64;
    localparam int ESC_R2  = 4096;
    localparam int FRAC    = 5;

    // Result flags
    localparam int BRIGHT_MIN = 6;
    localparam int WIDE_MIN   = 8;

    // Screen line: 16 + row*167/47 by reciprocal multiply, exact for 6-bit rows
    localparam int Y_TOP   = 16;
    localparam int Y_NUM   = 167;
    localparam int Y_DEN   = GRID_ROWS - 1;
    localparam int Y_SHIFT = 12;
    localparam int Y_MUL   = (Y_NUM * (1 << Y_SHIFT) + Y_DEN - 1) / Y_DEN;
    localparam int Y_MUL_W = $clog2(Y_MUL + 1);
    localparam int X_SHIFT = 2;

    // Register reset values
    localparam logic signed [C_W-1:0] C_REAL_RST = -8'sd22;
    localparam logic signed [C_W-1:0] C_IMAG_RST = 8'sd0;
    localparam logic [OFF_W-1:0]      OFF_RST    = 3'd0;

    // Configuration register indexes
    typedef enum logic [CFG_I_W-1:0] {
        REG_C_REAL    = 2'd0,
        REG_C_IMAG    = 2'd1,
        REG_COLOR_OFF = 2'd2
    } t_reg_idx;

    // One point travelling down the cell chain
    typedef struct packed {
        logic signed [Z_W-1:0] re;
        logic signed [Z_W-1:0] im;
        logic [CNT_W-1:0]      cnt;
        logic                  done;
        logic [COL_W-1:0]      col;
        logic [ROW_W-1:0]      row;
    } t_point;

    // Signed divide by 2^FRAC, truncating toward zero
    function automatic logic signed [SQ_W-1:0] div_frac(input logic signed [SQ_W-1:0] x);
        logic signed [SQ_W-1:0] bias;
        bias = x[SQ_W-1] ? SQ_W'((1 << FRAC) - 1) : '0;
        return (x + bias) >>> FRAC;
    endfunction

endpackage

FILE: hdl/jet_cell.sv
// ----------------------------------------------------------------------------
// jet_cell
// One iteration of z <- z*z/32 + c with escape test, registered hand-off.
// ----------------------------------------------------------------------------
module jet_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [jet_pkg::C_W-1:0]    i_c_real,
    input  logic signed [jet_pkg::C_W-1:0]    i_c_imag,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  jet_pkg::t_point                   i_point,
    output logic                              o_valid,
    input  logic                              i_ready,
    output jet_pkg::t_point                   o_point
);

    logic                                r_valid;
    jet_pkg::t_point                     r_point;
    jet_pkg::t_point                     n_point;
    logic signed [2*jet_pkg::Z_W-1:0]    w_re_sq;
    logic signed [2*jet_pkg::Z_W-1:0]    w_im_sq;
    logic signed [2*jet_pkg::Z_W-1:0]    w_cross;
    logic signed [jet_pkg::SQ_W-1:0]     w_r2;
    logic signed [jet_pkg::SQ_W-1:0]     w_diff;
    logic signed [jet_pkg::SQ_W-1:0]     w_dbl;
    logic signed [jet_pkg::SQ_W-1:0]     w_nre;
    logic signed [jet_pkg::SQ_W-1:0]     w_nim;
    logic                                w_esc;

    // Squares and cross term
    always_comb begin
        w_re_sq = i_point.re * i_point.re;
        w_im_sq = i_point.im * i_point.im;
        w_cross = i_point.re * i_point.im;
        w_r2    = jet_pkg::SQ_W'(w_re_sq) + jet_pkg::SQ_W'(w_im_sq);
        w_diff  = jet_pkg::SQ_W'(w_re_sq) - jet_pkg::SQ_W'(w_im_sq);
        w_dbl   = jet_pkg::SQ_W'(w_cross) <<< 1;
        w_nre   = jet_pkg::div_frac(w_diff) + jet_pkg::SQ_W'(i_c_real);
        w_nim   = jet_pkg::div_frac(w_dbl) + jet_pkg::SQ_W'(i_c_imag);
    end

    // Escape test runs ahead of the update
    always_comb begin
        w_esc = i_point.done
             || (i_point.re > jet_pkg::Z_W'(jet_pkg::ESC_MAG))
             || (i_point.re < jet_pkg::Z_W'(-jet_pkg::ESC_MAG))
             || (i_point.im > jet_pkg::Z_W'(jet_pkg::ESC_MAG))
             || (i_point.im < jet_pkg::Z_W'(-jet_pkg::ESC_MAG))
             || (w_r2 > jet_pkg::SQ_W'(jet_pkg::ESC_R2));
    end

    // Next point: freeze once escaped, else step and count
    always_comb begin
        n_point = i_point;
        if (w_esc) begin
            n_point.done = 1'b1;
        end else begin
            n_point.re  = jet_pkg::Z_W'(w_nre);
            n_point.im  = jet_pkg::Z_W'(w_nim);
            n_point.cnt = i_point.cnt + jet_pkg::CNT_W'(1);
        end
    end

    // Stage takes an item when empty or when its item moves on
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_point <= n_point;
        end
    end

    assign o_valid = r_valid;
    assign o_point = r_point;

endmodule

FILE: hdl/jet_out.sv
// ----------------------------------------------------------------------------
// jet_out
// Result stage: colour, flags and screen coordinates into the output register.
// ----------------------------------------------------------------------------
module jet_out (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [jet_pkg::OFF_W-1:0]      i_color_off,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  jet_pkg::t_point                i_point,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [jet_pkg::OUT_W-1:0]      o_tdata
);

    localparam int PAD_W = jet_pkg::OUT_W - jet_pkg::ITER_W - jet_pkg::OFF_W - 2
                         - 2 * jet_pkg::SCR_W;

    logic                                              r_valid;
    logic [jet_pkg::OUT_W-1:0]                         r_tdata;
    logic [jet_pkg::OUT_W-1:0]                         n_tdata;
    logic [jet_pkg::ROW_W+jet_pkg::Y_MUL_W-1:0]        w_ymul;
    logic [jet_pkg::ITER_W-1:0]                        w_iter;
    logic [jet_pkg::OFF_W-1:0]                         w_color;
    logic                                              w_bright;
    logic                                              w_wide;
    logic [jet_pkg::SCR_W-1:0]                         w_x;
    logic [jet_pkg::SCR_W-1:0]                         w_y;

    // Result fields
    always_comb begin
        w_iter   = jet_pkg::ITER_W'(i_point.cnt);
        w_color  = jet_pkg::OFF_W'(i_point.cnt) + i_color_off;
        w_bright = 32'(i_point.cnt) > jet_pkg::BRIGHT_MIN;
        w_wide   = 32'(i_point.cnt) > jet_pkg::WIDE_MIN;
        w_x      = jet_pkg::SCR_W'({i_point.col, {jet_pkg::X_SHIFT{1'b0}}});
        w_ymul   = (jet_pkg::ROW_W + jet_pkg::Y_MUL_W)'(i_point.row)
                 * (jet_pkg::ROW_W + jet_pkg::Y_MUL_W)'(jet_pkg::Y_MUL);
        w_y      = jet_pkg::SCR_W'(w_ymul >> jet_pkg::Y_SHIFT) + jet_pkg::SCR_W'(jet_pkg::Y_TOP);
        n_tdata  = {{PAD_W{1'b0}}, w_y, w_x, w_wide, w_bright, w_color, w_iter};
    end

    // Output register
    assign o_ready = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_tdata <= n_tdata;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_tdata;

endmodule

FILE: hdl/julia_escape_time_pixel_core.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_core
// Julia-set escape-time count per grid point, one iteration cell per step.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   col, row
//  m_axis    out        m_axis_tvalid/m_axis_tready   count, colour, flags, x, y
//  cfg       in         i_cfg_valid/o_cfg_ready       register index, data
//
//  One item per cycle while m_axis accepts; the chain is 12 iteration cells
//  and the result register. Each cell does one z*z/32 + c step with three
//  10x10 multipliers. Synchronous active-low reset empties the chain and
//  restores the register defaults. A stall at m_axis backs up cell by cell;
//  s_axis keeps taking items while any cell is empty.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // col [5:0], row [11:6], zero [15:12]
    input  logic [jet_pkg::IN_W-1:0]          s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // iterations [3:0], color [6:4], bright_flag [7], wide_flag [8],
    // screen_x [16:9], screen_y [24:17], zero [31:25]
    output logic [jet_pkg::OUT_W-1:0]         m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [jet_pkg::CFG_I_W-1:0]       i_cfg_index,
    input  logic [jet_pkg::C_W-1:0]           i_cfg_data
);

    localparam int N = jet_pkg::MAX_ITER;

    logic signed [jet_pkg::C_W-1:0]  r_c_real;
    logic signed [jet_pkg::C_W-1:0]  r_c_imag;
    logic [jet_pkg::OFF_W-1:0]       r_color_off;
    logic                            w_valid [0:N];
    logic                            w_ready [0:N];
    jet_pkg::t_point                 w_point [0:N];
    logic [jet_pkg::COL_W-1:0]       w_col;
    logic [jet_pkg::ROW_W-1:0]       w_row;
    jet_pkg::t_point                 w_start;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_real    <= jet_pkg::C_REAL_RST;
            r_c_imag    <= jet_pkg::C_IMAG_RST;
            r_color_off <= jet_pkg::OFF_RST;
        end else if (i_cfg_valid) begin
            case (jet_pkg::t_reg_idx'(i_cfg_index))
                jet_pkg::REG_C_REAL:    r_c_real    <= i_cfg_data;
                jet_pkg::REG_C_IMAG:    r_c_imag    <= i_cfg_data;
                jet_pkg::REG_COLOR_OFF: r_color_off <= i_cfg_data[jet_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Start point z = ((col-32)*3, (row-24)*3)
    assign w_col = s_axis_tdata[jet_pkg::COL_W-1:0];
    assign w_row = s_axis_tdata[jet_pkg::COL_W+jet_pkg::ROW_W-1:jet_pkg::COL_W];

    always_comb begin
        w_start.re   = jet_pkg::Z_W'((int'(w_col) - jet_pkg::COL_HALF)
                                     * jet_pkg::START_MUL);
        w_start.im   = jet_pkg::Z_W'((int'(w_row) - jet_pkg::ROW_HALF)
                                     * jet_pkg::START_MUL);
        w_start.cnt  = '0;
        w_start.done = 1'b0;
        w_start.col  = w_col;
        w_start.row  = w_row;
    end

    assign w_point[0]    = w_start;
    assign w_valid[0]    = s_axis_tvalid;
    assign s_axis_tready = w_ready[0];

    // Iteration cells
    for (genvar k = 0; k < N; k++) begin : g_cell
        jet_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_c_real (r_c_real),
            .i_c_imag (r_c_imag),
            .i_valid  (w_valid[k]),
            .o_ready  (w_ready[k]),
            .i_point  (w_point[k]),
            .o_valid  (w_valid[k+1]),
            .i_ready  (w_ready[k+1]),
            .o_point  (w_point[k+1])
        );
    end

    // Result register
    jet_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_color_off (r_color_off),
        .i_valid     (w_valid[N]),
        .o_ready     (w_ready[N]),
        .i_point     (w_point[N]),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // An accepted item always lands in the first cell
    a_first_cell_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> w_valid[1])
        else $error("accepted item missing from first cell");

    // A point that never escaped leaves the chain with the full count
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[N] && !w_point[N].done) |-> (32'(w_point[N].cnt) == N))
        else $error("unescaped point with short count");

    // A stalled last cell keeps its item
    a_last_cell_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[N] && !w_ready[N]) |=> (w_valid[N] && $stable(w_point[N])))
        else $error("last cell dropped a stalled item");
`endif

endmodule

FILE: tb/tb_julia_escape_time_pixel_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_julia_escape_time_pixel_core
// Self-checking bench for the Julia escape-time pixel core. Grid points go
// in over s_axis in random bursts, results come back over m_axis under a
// stalling sink, and each one is compared field by field with a local
// fixed-point escape-time predictor. The Julia constant and the colour
// offset are reprogrammed between frames, extremes included.
// ----------------------------------------------------------------------------
module tb_julia_escape_time_pixel_core;

    import jet_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_FRAMES = 8;
    localparam int FRAME_ITEMS = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_PAD   = MAX_ITER + 6;

    // index 3 is decoded by nothing; writes there must change nothing
    localparam logic [CFG_I_W-1:0] REG_SPARE = 2'd3;

    // one expected pixel result
    typedef struct packed {
        logic [ITER_W-1:0] iterations;
        logic [OFF_W-1:0]  color;
        logic              bright_flag;
        logic              wide_flag;
        logic [SCR_W-1:0]  screen_x;
        logic [SCR_W-1:0]  screen_y;
    } pix_result_t;

    // DUT ports
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_I_W-1:0]   i_cfg_index   = '0;
    logic [C_W-1:0]       i_cfg_data    = '0;

    // local copy of the Julia constant and colour offset
    logic signed [C_W-1:0] julia_c_re  = C_REAL_RST;
    logic signed [C_W-1:0] julia_c_im  = C_IMAG_RST;
    logic [OFF_W-1:0]      ink_offset  = OFF_RST;

    pix_result_t pending_pixels[$];
    int          mismatches  = 0;
    int          cycle_count = 0;

    // sender burst shaping
    int burst_left = 0;
    int gap_max    = 0;

    // sink stall control
    int sink_mode  = 0;
    int hold_req   = 0;
    int hold_left  = 0;
    int sink_phase = 0;

    julia_escape_time_pixel_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_julia_escape_time_pixel_core NOT OK");
            $finish;
        end
    end

    // escape-time predictor: escape test ahead of every z*z/32 + c update
    function automatic pix_result_t escape_pixel(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
        int re;
        int im;
        int re_next;
        int n;
        pix_result_t r;
        re = (int'(col) - COL_HALF) * START_MUL;
        im = (int'(row) - ROW_HALF) * START_MUL;
        n  = 0;
        while (n < MAX_ITER) begin
            if (re > ESC_MAG || -re > ESC_MAG || im > ESC_MAG || -im > ESC_MAG)
                break;
            if (re * re + im * im > ESC_R2)
                break;
            re_next = (re * re - im * im) / 32 + int'(julia_c_re);
            im      = (2 * re * im) / 32 + int'(julia_c_im);
            re      = re_next;
            n++;
        end
        r.iterations  = ITER_W'(n);
        r.color       = OFF_W'(n + int'(ink_offset));
        r.bright_flag = (n > BRIGHT_MIN);
        r.wide_flag   = (n > WIDE_MIN);
        r.screen_x    = SCR_W'(int'(col) * 4);
        r.screen_y    = SCR_W'(Y_TOP + int'(row) * Y_NUM / Y_DEN);
        return r;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // sink: check each accepted pixel, then pick next ready
    always @(posedge i_clk) begin : sink_side
        pix_result_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel result with nothing expected: %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                compare_field("iterations",  want.iterations,  m_axis_tdata[3:0]);
                compare_field("color",       want.color,       m_axis_tdata[6:4]);
                compare_field("bright_flag", want.bright_flag, m_axis_tdata[7]);
                compare_field("wide_flag",   want.wide_flag,   m_axis_tdata[8]);
                compare_field("screen_x",    want.screen_x,    m_axis_tdata[16:9]);
                compare_field("screen_y",    want.screen_y,    m_axis_tdata[24:17]);
                compare_field("pad",         0,                m_axis_tdata[31:25]);
            end
        end
        sink_phase++;
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (sink_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= ($urandom_range(0, 2) != 0);
                end
                default: begin
                    m_axis_tready <= ((sink_phase % 11) < 7);
                end
            endcase
        end
    end

    // offer one grid point; tvalid stays high after accept for the caller
    task automatic send_point(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= IN_W'({row, col});
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_pixels.push_back(escape_pixel(col, row));
    endtask

    // stop offering and wait for every outstanding pixel
    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    // reprogram the constant and offset while the core is empty
    task automatic program_constant(input logic signed [C_W-1:0] c_re,
                                    input logic signed [C_W-1:0] c_im,
                                    input logic [C_W-1:0]        off_data,
                                    input bit                    touch_spare);
        logic [CFG_I_W-1:0] idx[4];
        logic [C_W-1:0]     dat[4];
        int                 n;
        drain_pixels();
        idx[0] = REG_C_REAL;    dat[0] = c_re;
        idx[1] = REG_C_IMAG;    dat[1] = c_im;
        idx[2] = REG_COLOR_OFF; dat[2] = off_data;
        idx[3] = REG_SPARE;     dat[3] = 8'($urandom_range(0, 255));
        n = touch_spare ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data  <= dat[k];
            i_cfg_valid <= 1'b1;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx[k])
                REG_C_REAL:    julia_c_re = dat[k];
                REG_C_IMAG:    julia_c_im = dat[k];
                REG_COLOR_OFF: ink_offset = dat[k][OFF_W-1:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // corners, center, bit patterns and rows past the grid, reset constant
    task automatic test_reset_defaults();
        gap_max   = 0;
        sink_mode = 0;
        send_point(6'd0,  6'd0);
        send_point(6'd63, 6'd0);
        send_point(6'd0,  6'd47);
        send_point(6'd63, 6'd47);
        send_point(6'd32, 6'd24);
        send_point(6'd31, 6'd23);
        send_point(6'd33, 6'd25);
        send_point(6'd42, 6'd21);
        send_point(6'd21, 6'd42);
        send_point(6'd30, 6'd26);
        // rows beyond the grid
        send_point(6'd32, 6'd48);
        send_point(6'd5,  6'd63);
        send_point(6'd63, 6'd63);
    endtask

    // constant and offset at their extremes, then a moderate set; spare register written with the extremes
    task automatic test_config_extremes();
        program_constant(-8'sd128, 8'sd127, 8'hFF, 1'b1);
        gap_max   = 3;
        sink_mode = 1;
        send_point(6'd32, 6'd24);
        send_point(6'd0,  6'd63);
        send_point(6'd40, 6'd30);
        program_constant(8'sd127, -8'sd128, 8'h00, 1'b1);
        send_point(6'd32, 6'd24);
        send_point(6'd24, 6'd18);
        program_constant(-8'sd10, 8'sd20, 8'hFD, 1'b0);
        send_point(6'd32, 6'd24);
        send_point(6'd36, 6'd28);
        send_point(6'd28, 6'd20);
    endtask

    // sink holds off long enough for the chain to fill and stall s_axis
    task automatic test_backpressure();
        program_constant(-8'sd22, 8'sd0, 8'h03, 1'b0);
        gap_max   = 0;
        sink_mode = 0;
        hold_req  = HOLD_CYCLES;
        for (int k = 0; k < 60; k++)
            send_point(6'($urandom_range(16, 48)), 6'($urandom_range(8, 40)));
    endtask

    // random frames, each with its own constant and idling profile
    task automatic test_random_frames();
        logic signed [C_W-1:0] c_re;
        logic signed [C_W-1:0] c_im;
        int                    sel;
        for (int f = 0; f < RAND_FRAMES; f++) begin
            if (f == 0) begin
                c_re = -8'sd128;
                c_im = 8'sd127;
            end else if (f == 1) begin
                c_re = 8'sd127;
                c_im = -8'sd128;
            end else if ($urandom_range(0, 3) == 0) begin
                c_re = 8'($urandom_range(0, 255));
                c_im = 8'($urandom_range(0, 255));
            end else begin
                c_re = 8'(int'($urandom_range(0, 60)) - 30);
                c_im = 8'(int'($urandom_range(0, 60)) - 30);
            end
            program_constant(c_re, c_im, 8'($urandom_range(0, 255)), f == 3);
            gap_max   = (f % 3 == 0) ? 0 : $urandom_range(1, 8);
            sink_mode = f % 3;
            for (int k = 0; k < FRAME_ITEMS; k++) begin
                sel = $urandom_range(0, 9);
                if (sel < 4)
                    send_point(6'($urandom_range(20, 44)), 6'($urandom_range(12, 36)));
                else if (sel < 8)
                    send_point(6'($urandom_range(0, 63)), 6'($urandom_range(0, 47)));
                else
                    send_point(6'($urandom_range(0, 63)), 6'($urandom_range(48, 63)));
            end
        end
    endtask

    // test sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_config_extremes();
        test_backpressure();
        test_random_frames();
        drain_pixels();
        repeat (DRAIN_PAD) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_julia_escape_time_pixel_core OK");
        else
            $display("tb_julia_escape_time_pixel_core NOT OK");
        $finish;
    end

endmodule
